>>> rtl/scdm_pkg.sv
// Shared types, codes and helpers for the direct-mapped score cache.
`default_nettype none

package scdm_pkg;

   // Default table geometry
   localparam int INDEX_BITS_DEF = 12;

   // Word layout: tag in the upper bits, biased score in the low bits
   localparam int WORD_BITS  = 64;
   localparam int SCORE_BITS = 16;
   localparam int TAG_BITS   = WORD_BITS - SCORE_BITS;
   localparam int HAND_BITS  = 32;

   localparam logic [SCORE_BITS-1:0] SCORE_BIAS = 16'h8000;

   // Operation codes
   localparam logic [1:0] OP_PROBE = 2'd0;
   localparam logic [1:0] OP_STORE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]                    opcode;
      logic [WORD_BITS-1:0]          key;
      logic [HAND_BITS-1:0]          hand;
      logic signed [SCORE_BITS-1:0]  score_in;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [SCORE_BITS-1:0]  score_out;
   } rsp_type;

   // Write request into the entry table
   typedef struct packed {
      logic                  en;
      logic [WORD_BITS-1:0]  word;
   } wr_req_type;

   // Tag: key bits above the score field, with the hand word mixed in at the bottom
   function automatic logic [TAG_BITS-1:0] make_tag(input logic [WORD_BITS-1:0] key,
                                                    input logic [HAND_BITS-1:0] hand);
      make_tag = key[WORD_BITS-1:SCORE_BITS] ^ {{(TAG_BITS-HAND_BITS){1'b0}}, hand};
   endfunction

endpackage

`default_nettype wire

>>> rtl/scdm_table.sv
// Entry table memory with its clearing sweep.
`default_nettype none

module scdm_table #(
   parameter int INDEX_BITS = scdm_pkg::INDEX_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rd_en,
   input  wire logic [INDEX_BITS-1:0]           rd_addr,
   output logic [scdm_pkg::WORD_BITS-1:0]       rd_data,
   input  wire scdm_pkg::wr_req_type            wr_req,
   input  wire logic [INDEX_BITS-1:0]           wr_addr,
   input  wire logic                            clr_start,
   output logic                                 busy
);

   localparam int DEPTH = 1 << INDEX_BITS;

   logic [scdm_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [scdm_pkg::WORD_BITS-1:0] rd_data_ff;
   logic [INDEX_BITS-1:0]          clr_cnt_ff, clr_cnt_in;
   logic                           busy_ff, busy_in;

   // Advance the sweep one entry a cycle; restart on reset or a clear request
   always_comb begin
      busy_in    = busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (&clr_cnt_ff) begin
            busy_in = 1'b0;
         end
      end else if (clr_start) begin
         busy_in    = 1'b1;
         clr_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Single write port shared by the sweep and stores
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_req.en) begin
         mem[wr_addr] <= wr_req.word;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

>>> rtl/score_cache_direct_mapped.sv
// Top level of the direct-mapped score cache: request decode, probe compare and response register.
`default_nettype none

// Direct-mapped cache of 2^INDEX_BITS 64-bit words, indexed by the low key bits. Probes and
// stores are taken one per cycle unless the table is sweeping or a probe waits on a full
// response register. A probe's tag is held in the stage register while the table read is
// registered, and its result then enters the response register. The response register lets
// the next request in while a response waits. Stores and clears give no response. The table
// lives in one memory with one write port, so after reset and after every clear the block
// sweeps it to zero one entry a cycle and takes no request until every entry is cleared.
module score_cache_direct_mapped #(
   parameter int INDEX_BITS = scdm_pkg::INDEX_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire scdm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output scdm_pkg::rsp_type      rsp_data
);

   logic                               req_acc;
   logic                               is_probe, is_store, is_clear;
   logic [INDEX_BITS-1:0]              idx;
   logic [scdm_pkg::WORD_BITS-1:0]     rd_data;
   logic                               busy;
   scdm_pkg::wr_req_type               wr_req;

   logic                               s1_vld_ff, s1_vld_in;
   logic [scdm_pkg::TAG_BITS-1:0]      s1_tag_ff;
   logic                               s1_go;
   logic                               rsp_vld_ff, rsp_vld_in;
   scdm_pkg::rsp_type                  rsp_ff, rsp_calc;

   // Decode the request word
   assign idx      = req_data.key[INDEX_BITS-1:0];
   assign is_probe = req_data.opcode == scdm_pkg::OP_PROBE;
   assign is_store = req_data.opcode == scdm_pkg::OP_STORE;
   assign is_clear = req_data.opcode == scdm_pkg::OP_CLEAR;

   // Hold requests while sweeping or while a probe waits on a full response register
   assign s1_go     = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = busy || (s1_vld_ff && !s1_go);
   assign req_acc   = req_valid && !req_stall;

   // Build the stored word for a store
   assign wr_req.en   = req_acc && is_store;
   assign wr_req.word = {scdm_pkg::make_tag(req_data.key, req_data.hand),
                         req_data.score_in ^ scdm_pkg::SCORE_BIAS};

   scdm_table #(
      .INDEX_BITS(INDEX_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_acc && is_probe),
      .rd_addr   (idx),
      .rd_data   (rd_data),
      .wr_req    (wr_req),
      .wr_addr   (idx),
      .clr_start (req_acc && is_clear),
      .busy      (busy)
   );

   // Compare the stored tag with the probe tag and unbias the score
   always_comb begin
      rsp_calc.hit       = rd_data[scdm_pkg::WORD_BITS-1:scdm_pkg::SCORE_BITS] == s1_tag_ff;
      rsp_calc.score_out = '0;
      if (rsp_calc.hit) begin
         rsp_calc.score_out = rd_data[scdm_pkg::SCORE_BITS-1:0] ^ scdm_pkg::SCORE_BIAS;
      end
   end

   // Track the probe in flight and the response word
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (s1_go) begin
         s1_vld_in = 1'b0;
      end
      if (req_acc && is_probe) begin
         s1_vld_in = 1'b1;
      end
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
      if (s1_go) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_acc && is_probe) begin
         s1_tag_ff <= scdm_pkg::make_tag(req_data.key, req_data.hand);
      end
      if (s1_go) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/scdm_checker.sv
// Port-level checks for the direct-mapped score cache, bound to its top level.
`default_nettype none

module scdm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire scdm_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire scdm_pkg::rsp_type rsp_data
);

   // A stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // A miss carries a zero score
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.score_out == '0)
      else $error("miss with nonzero score");

   // Reset starts the table sweep, which holds off requests
   assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken right after reset");

   // A taken clear starts the sweep
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == scdm_pkg::OP_CLEAR |=> req_stall)
      else $error("request taken right after clear");

endmodule

bind score_cache_direct_mapped scdm_checker u_scdm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
